// ===== rtl/assert_macros.svh =====
// Assertion shorthands used by the top-level RTL file.
// Needs a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/dcr_pkg.sv =====
// Types, stage map and helper functions of the disc collision response unit.
// No dependencies; used by dcr_core, disc_collision_response_unit and the testbench.
package dcr_pkg;

  localparam int unsigned NumStages = 72;
  localparam int unsigned StIn      = 0;
  localparam int unsigned StMul     = 1;
  localparam int unsigned StCmp     = 2;
  localparam int unsigned StSqrt    = 3;
  localparam int unsigned WgtSteps  = 26;
  localparam int unsigned StNrm     = 35;
  localparam int unsigned NrmSteps  = 29;
  localparam int unsigned StSign    = 64;
  localparam int unsigned StProj    = 65;
  localparam int unsigned StSum     = 66;
  localparam int unsigned StGap     = 67;
  localparam int unsigned StImp     = 68;
  localparam int unsigned StNew     = 69;
  localparam int unsigned StRot     = 70;
  localparam int unsigned StOut     = 71;

  localparam int unsigned NrmBits = 28;
  localparam int unsigned WgtBits = 24;
  localparam logic [16:0] EOne    = 17'd65536;

  typedef struct packed {
    logic signed [31:0] p1x;
    logic signed [31:0] p1y;
    logic signed [31:0] v1x;
    logic signed [31:0] v1y;
    logic signed [31:0] p2x;
    logic signed [31:0] p2y;
    logic signed [31:0] v2x;
    logic signed [31:0] v2y;
    logic [30:0]        reach1;
    logic [30:0]        reach2;
    logic [30:0]        mass1;
    logic [30:0]        mass2;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] p1x;
    logic signed [31:0] p1y;
    logic signed [31:0] v1x;
    logic signed [31:0] v1y;
    logic signed [31:0] p2x;
    logic signed [31:0] p2y;
    logic signed [31:0] v2x;
    logic signed [31:0] v2y;
  } out_t;

  typedef struct packed {
    logic signed [31:0] p1x;
    logic signed [31:0] p1y;
    logic signed [31:0] v1x;
    logic signed [31:0] v1y;
    logic signed [31:0] p2x;
    logic signed [31:0] p2y;
    logic signed [31:0] v2x;
    logic signed [31:0] v2y;
    logic               sgnx;
    logic               sgny;
    logic [31:0]        adx;
    logic [31:0]        ady;
    logic [31:0]        rsum;
    logic [30:0]        m1;
    logic [30:0]        m2;
    logic [17:0]        q;
    logic [63:0]        a;
    logic [63:0]        b;
    logic [63:0]        r2;
    logic [56:0]        n1;
    logic [56:0]        n2;
    logic [31:0]        msum;
    logic               hit;
    logic [63:0]        sqx;
    logic [63:0]        sqr;
    logic [25:0]        w1;
    logic [25:0]        w2;
    logic [31:0]        dlen;
    logic [30:0]        half;
    logic [59:0]        rx;
    logic [59:0]        ry;
    logic [28:0]        qx;
    logic [28:0]        qy;
    logic signed [29:0] nx;
    logic signed [29:0] ny;
    logic signed [61:0] pa1;
    logic signed [61:0] pb1;
    logic signed [61:0] pc1;
    logic signed [61:0] pd1;
    logic signed [61:0] pa2;
    logic signed [61:0] pb2;
    logic signed [61:0] pc2;
    logic signed [61:0] pd2;
    logic signed [61:0] psx;
    logic signed [61:0] psy;
    logic signed [34:0] vn1;
    logic signed [34:0] vt1;
    logic signed [34:0] vn2;
    logic signed [34:0] vt2;
    logic signed [31:0] np1x;
    logic signed [31:0] np1y;
    logic signed [31:0] np2x;
    logic signed [31:0] np2y;
    logic signed [35:0] g;
    logic signed [62:0] gw1;
    logic signed [62:0] gw2;
    logic signed [35:0] vf1;
    logic signed [35:0] vf2;
    logic signed [65:0] e1;
    logic signed [65:0] f1;
    logic signed [65:0] h1;
    logic signed [65:0] i1;
    logic signed [65:0] e2;
    logic signed [65:0] f2;
    logic signed [65:0] h2;
    logic signed [65:0] i2;
    out_t               res;
  } pipe_t;

  localparam logic signed [47:0] SatHi = 48'sd2147483647;
  localparam logic signed [47:0] SatLo = -48'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > SatHi) begin
      r = 32'sh7FFFFFFF;
    end else if (v < SatLo) begin
      r = 32'sh80000000;
    end else begin
      r = $signed(v[31:0]);
    end
    return r;
  endfunction

endpackage

// ===== rtl/dcr_core.sv =====
// Datapath pipeline of the disc collision response unit: one stage per register.
// Depends on dcr_pkg; stage enables come from the top level.
module dcr_core
  import dcr_pkg::*;
(
  input  logic                 clk_i,
  input  logic [NumStages-1:0] adv_i,
  input  in_t                  in_i,
  input  logic [16:0]          rest_i,
  output out_t                 out_o
);

  pipe_t st_q [NumStages];

  for (genvar k = 0; k < NumStages; k++) begin : g_st
    pipe_t d;

    if (k == StIn) begin : g_in
      logic [32:0] dx, dy;
      logic [16:0] e;
      assign dx = {in_i.p2x[31], in_i.p2x} - {in_i.p1x[31], in_i.p1x};
      assign dy = {in_i.p2y[31], in_i.p2y} - {in_i.p1y[31], in_i.p1y};
      assign e  = (rest_i > EOne) ? EOne : rest_i;
      always_comb begin
        d      = '0;
        d.p1x  = in_i.p1x;
        d.p1y  = in_i.p1y;
        d.v1x  = in_i.v1x;
        d.v1y  = in_i.v1y;
        d.p2x  = in_i.p2x;
        d.p2y  = in_i.p2y;
        d.v2x  = in_i.v2x;
        d.v2y  = in_i.v2y;
        d.sgnx = dx[32];
        d.sgny = dy[32];
        d.adx  = dx[32] ? 32'(~dx + 33'd1) : dx[31:0];
        d.ady  = dy[32] ? 32'(~dy + 33'd1) : dy[31:0];
        d.rsum = 32'(in_i.reach1) + 32'(in_i.reach2);
        d.m1   = (in_i.mass1 == '0) ? 31'd1 : in_i.mass1;
        d.m2   = (in_i.mass2 == '0) ? 31'd1 : in_i.mass2;
        d.q    = 18'(EOne) + 18'(e);
      end
    end else if (k == StMul) begin : g_mul
      always_comb begin
        d      = st_q[k-1];
        d.a    = 64'(st_q[k-1].adx) * 64'(st_q[k-1].adx);
        d.b    = 64'(st_q[k-1].ady) * 64'(st_q[k-1].ady);
        d.r2   = 64'(st_q[k-1].rsum) * 64'(st_q[k-1].rsum);
        d.n1   = {49'(st_q[k-1].m1) * 49'(st_q[k-1].q), 8'b0};
        d.n2   = {49'(st_q[k-1].m2) * 49'(st_q[k-1].q), 8'b0};
        d.msum = 32'(st_q[k-1].m1) + 32'(st_q[k-1].m2);
      end
    end else if (k == StCmp) begin : g_cmp
      logic [64:0] d2;
      assign d2 = {1'b0, st_q[k-1].a} + {1'b0, st_q[k-1].b};
      always_comb begin
        d     = st_q[k-1];
        d.hit = (d2 != '0) && (d2 < {1'b0, st_q[k-1].r2});
        d.sqx = d2[63:0];
        d.sqr = '0;
        d.w1  = '0;
        d.w2  = '0;
      end
    end else if (k >= StSqrt && k < StNrm) begin : g_sqrt
      // One root bit per stage; the mass weights divide alongside.
      localparam int unsigned I = k - StSqrt;
      localparam logic [63:0] RootBit = 64'd1 << (62 - 2 * I);
      localparam int unsigned Wj = (I < WgtSteps) ? (WgtSteps - 1 - I) : 0;
      logic [64:0] trial;
      logic [57:0] tw;
      assign trial = {1'b0, st_q[k-1].sqr} + {1'b0, RootBit};
      assign tw    = 58'(st_q[k-1].msum) << Wj;
      always_comb begin
        d = st_q[k-1];
        if ({1'b0, st_q[k-1].sqx} >= trial) begin
          d.sqx = st_q[k-1].sqx - trial[63:0];
          d.sqr = (st_q[k-1].sqr >> 1) + RootBit;
        end else begin
          d.sqr = st_q[k-1].sqr >> 1;
        end
        if (I < WgtSteps) begin
          if ({1'b0, st_q[k-1].n1} >= tw) begin
            d.n1     = st_q[k-1].n1 - tw[56:0];
            d.w1[Wj] = 1'b1;
          end
          if ({1'b0, st_q[k-1].n2} >= tw) begin
            d.n2     = st_q[k-1].n2 - tw[56:0];
            d.w2[Wj] = 1'b1;
          end
        end
      end
    end else if (k >= StNrm && k < StSign) begin : g_nrm
      // Restoring divide of |d| << 28 by the distance, one quotient bit a stage.
      localparam int unsigned I  = k - StNrm;
      localparam int unsigned Nj = NrmSteps - 1 - I;
      logic [31:0] dv;
      logic [59:0] rxs, rys;
      logic [28:0] qxs, qys;
      logic [31:0] rdiff;
      logic [60:0] tn;
      if (I == 0) begin : g_first
        assign dv  = st_q[k-1].sqr[31:0];
        assign rxs = {st_q[k-1].adx, 28'b0};
        assign rys = {st_q[k-1].ady, 28'b0};
        assign qxs = '0;
        assign qys = '0;
      end else begin : g_next
        assign dv  = st_q[k-1].dlen;
        assign rxs = st_q[k-1].rx;
        assign rys = st_q[k-1].ry;
        assign qxs = st_q[k-1].qx;
        assign qys = st_q[k-1].qy;
      end
      assign rdiff = st_q[k-1].rsum - dv;
      assign tn    = 61'(dv) << Nj;
      always_comb begin
        d      = st_q[k-1];
        d.dlen = dv;
        d.rx   = rxs;
        d.ry   = rys;
        d.qx   = qxs;
        d.qy   = qys;
        if (I == 0) begin
          d.half = rdiff[31:1];
        end
        if ({1'b0, rxs} >= tn) begin
          d.rx     = rxs - tn[59:0];
          d.qx[Nj] = 1'b1;
        end
        if ({1'b0, rys} >= tn) begin
          d.ry     = rys - tn[59:0];
          d.qy[Nj] = 1'b1;
        end
      end
    end else if (k == StSign) begin : g_sign
      always_comb begin
        d    = st_q[k-1];
        d.nx = st_q[k-1].sgnx ? -$signed({1'b0, st_q[k-1].qx}) : $signed({1'b0, st_q[k-1].qx});
        d.ny = st_q[k-1].sgny ? -$signed({1'b0, st_q[k-1].qy}) : $signed({1'b0, st_q[k-1].qy});
      end
    end else if (k == StProj) begin : g_proj
      pipe_t s;
      assign s = st_q[k-1];
      always_comb begin
        d     = s;
        d.pa1 = 62'($signed(s.v1x)) * 62'($signed(s.nx));
        d.pb1 = 62'($signed(s.v1y)) * 62'($signed(s.ny));
        d.pc1 = 62'($signed(s.v1y)) * 62'($signed(s.nx));
        d.pd1 = 62'($signed(s.v1x)) * 62'($signed(s.ny));
        d.pa2 = 62'($signed(s.v2x)) * 62'($signed(s.nx));
        d.pb2 = 62'($signed(s.v2y)) * 62'($signed(s.ny));
        d.pc2 = 62'($signed(s.v2y)) * 62'($signed(s.nx));
        d.pd2 = 62'($signed(s.v2x)) * 62'($signed(s.ny));
        d.psx = 62'($signed(s.nx)) * 62'($signed({1'b0, s.half}));
        d.psy = 62'($signed(s.ny)) * 62'($signed({1'b0, s.half}));
      end
    end else if (k == StSum) begin : g_sum
      pipe_t s;
      logic signed [33:0] sx, sy;
      assign s  = st_q[k-1];
      assign sx = 34'($signed(s.psx) >>> NrmBits);
      assign sy = 34'($signed(s.psy) >>> NrmBits);
      always_comb begin
        d      = s;
        d.vn1  = 35'((63'($signed(s.pa1)) + 63'($signed(s.pb1))) >>> NrmBits);
        d.vt1  = 35'((63'($signed(s.pc1)) - 63'($signed(s.pd1))) >>> NrmBits);
        d.vn2  = 35'((63'($signed(s.pa2)) + 63'($signed(s.pb2))) >>> NrmBits);
        d.vt2  = 35'((63'($signed(s.pc2)) - 63'($signed(s.pd2))) >>> NrmBits);
        d.np1x = sat32(48'($signed(s.p1x)) - 48'(sx));
        d.np1y = sat32(48'($signed(s.p1y)) - 48'(sy));
        d.np2x = sat32(48'($signed(s.p2x)) + 48'(sx));
        d.np2y = sat32(48'($signed(s.p2y)) + 48'(sy));
      end
    end else if (k == StGap) begin : g_gap
      always_comb begin
        d   = st_q[k-1];
        d.g = 36'($signed(st_q[k-1].vn1)) - 36'($signed(st_q[k-1].vn2));
      end
    end else if (k == StImp) begin : g_imp
      always_comb begin
        d     = st_q[k-1];
        d.gw1 = 63'($signed(st_q[k-1].g)) * 63'($signed({1'b0, st_q[k-1].w1}));
        d.gw2 = 63'($signed(st_q[k-1].g)) * 63'($signed({1'b0, st_q[k-1].w2}));
      end
    end else if (k == StNew) begin : g_new
      pipe_t s;
      assign s = st_q[k-1];
      always_comb begin
        d     = s;
        d.vf1 = 36'(48'($signed(s.vn1)) - 48'($signed(s.gw2) >>> WgtBits));
        d.vf2 = 36'(48'($signed(s.vn2)) + 48'($signed(s.gw1) >>> WgtBits));
      end
    end else if (k == StRot) begin : g_rot
      pipe_t s;
      assign s = st_q[k-1];
      always_comb begin
        d    = s;
        d.e1 = 66'($signed(s.nx)) * 66'($signed(s.vf1));
        d.f1 = 66'($signed(s.ny)) * 66'($signed(s.vt1));
        d.h1 = 66'($signed(s.ny)) * 66'($signed(s.vf1));
        d.i1 = 66'($signed(s.nx)) * 66'($signed(s.vt1));
        d.e2 = 66'($signed(s.nx)) * 66'($signed(s.vf2));
        d.f2 = 66'($signed(s.ny)) * 66'($signed(s.vt2));
        d.h2 = 66'($signed(s.ny)) * 66'($signed(s.vf2));
        d.i2 = 66'($signed(s.nx)) * 66'($signed(s.vt2));
      end
    end else begin : g_out
      pipe_t s;
      assign s = st_q[k-1];
      always_comb begin
        d         = s;
        d.res.hit = s.hit;
        if (s.hit) begin
          d.res.p1x = s.np1x;
          d.res.p1y = s.np1y;
          d.res.p2x = s.np2x;
          d.res.p2y = s.np2y;
          d.res.v1x = sat32(48'((67'($signed(s.e1)) - 67'($signed(s.f1))) >>> NrmBits));
          d.res.v1y = sat32(48'((67'($signed(s.h1)) + 67'($signed(s.i1))) >>> NrmBits));
          d.res.v2x = sat32(48'((67'($signed(s.e2)) - 67'($signed(s.f2))) >>> NrmBits));
          d.res.v2y = sat32(48'((67'($signed(s.h2)) + 67'($signed(s.i2))) >>> NrmBits));
        end else begin
          d.res.p1x = s.p1x;
          d.res.p1y = s.p1y;
          d.res.p2x = s.p2x;
          d.res.p2y = s.p2y;
          d.res.v1x = s.v1x;
          d.res.v1y = s.v1y;
          d.res.v2x = s.v2x;
          d.res.v2y = s.v2y;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i[k]) begin
        st_q[k] <= d;
      end
    end
  end

  assign out_o = st_q[StOut].res;

endmodule

// ===== rtl/disc_collision_response_unit.sv =====
// Top level of the disc collision response unit: handshakes, restitution register, checks.
// Depends on dcr_pkg, dcr_core and assert_macros.svh.
//
//  channel | direction | handshake                 | word
//  --------+-----------+---------------------------+------------------------------------
//  in      | in        | in_valid_i / in_ready_o   | positions, velocities, reaches, masses
//  out     | out       | out_valid_o / out_ready_i | hit flag and eight resolved values
//  cfg     | in        | cfg_valid_i / cfg_ready_o | restitution, unsigned Q1.16
//
// One disc pair enters per cycle while in_ready_o is high; its result is offered from
// the last stage, StOut, and leaves at the first edge after that with out_ready_i high.
// The depth is set by the 32-stage square root followed by the 29-stage normal divider,
// plus eleven single stages around them; the mass weights divide beside the root.
// Reset clears every stage valid bit and sets restitution to 1.0; data registers keep junk.
// A stalled stage holds its word; the one behind it may still advance into a bubble,
// so words keep entering free stages while a finished result waits on the output.
`include "assert_macros.svh"

module disc_collision_response_unit
  import dcr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] first_pos_x_i,
  input  logic signed [31:0] first_pos_y_i,
  input  logic signed [31:0] first_vel_x_i,
  input  logic signed [31:0] first_vel_y_i,
  input  logic signed [31:0] second_pos_x_i,
  input  logic signed [31:0] second_pos_y_i,
  input  logic signed [31:0] second_vel_x_i,
  input  logic signed [31:0] second_vel_y_i,
  input  logic [30:0]        first_reach_i,
  input  logic [30:0]        second_reach_i,
  input  logic [30:0]        first_mass_i,
  input  logic [30:0]        second_mass_i,

  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               hit_o,
  output logic signed [31:0] new_first_pos_x_o,
  output logic signed [31:0] new_first_pos_y_o,
  output logic signed [31:0] new_first_vel_x_o,
  output logic signed [31:0] new_first_vel_y_o,
  output logic signed [31:0] new_second_pos_x_o,
  output logic signed [31:0] new_second_pos_y_o,
  output logic signed [31:0] new_second_vel_x_o,
  output logic signed [31:0] new_second_vel_y_o,

  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [16:0]        cfg_restitution_i
);

  logic [16:0]          restitution_q, restitution_d;
  logic [NumStages-1:0] valid_q, valid_d;
  logic [NumStages:0]   adv;
  logic                 in_fire, out_fire;
  in_t                  in_word;
  out_t                 out_word;

  // Restitution register: writes are always taken.
  assign cfg_ready_o   = 1'b1;
  assign restitution_d = (cfg_valid_i && cfg_ready_o) ? cfg_restitution_i : restitution_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restitution_q <= EOne;
    end else begin
      restitution_q <= restitution_d;
    end
  end

  // A stage advances when it is empty or the stage after it advances.
  assign adv[NumStages] = out_ready_i;
  for (genvar k = 0; k < NumStages; k++) begin : g_adv
    assign adv[k] = !valid_q[k] || adv[k+1];
  end

  always_comb begin
    valid_d = valid_q;
    if (adv[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (adv[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = valid_q[StOut];
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_o && out_ready_i;

  assign in_word.p1x    = first_pos_x_i;
  assign in_word.p1y    = first_pos_y_i;
  assign in_word.v1x    = first_vel_x_i;
  assign in_word.v1y    = first_vel_y_i;
  assign in_word.p2x    = second_pos_x_i;
  assign in_word.p2y    = second_pos_y_i;
  assign in_word.v2x    = second_vel_x_i;
  assign in_word.v2y    = second_vel_y_i;
  assign in_word.reach1 = first_reach_i;
  assign in_word.reach2 = second_reach_i;
  assign in_word.mass1  = first_mass_i;
  assign in_word.mass2  = second_mass_i;

  dcr_core u_core (
    .clk_i  (clk_i),
    .adv_i  (adv[NumStages-1:0]),
    .in_i   (in_word),
    .rest_i (restitution_q),
    .out_o  (out_word)
  );

  assign hit_o              = out_word.hit;
  assign new_first_pos_x_o  = out_word.p1x;
  assign new_first_pos_y_o  = out_word.p1y;
  assign new_first_vel_x_o  = out_word.v1x;
  assign new_first_vel_y_o  = out_word.v1y;
  assign new_second_pos_x_o = out_word.p2x;
  assign new_second_pos_y_o = out_word.p2y;
  assign new_second_vel_x_o = out_word.v2x;
  assign new_second_vel_y_o = out_word.v2y;

  // Input backs up only when every stage holds a word.
  `ASSERT_IMPL(a_full_before_stall, !in_ready_o, &valid_q)
  // Words in flight change only by what enters and what leaves.
  `ASSERT_NEXT(a_word_count, 1'b1, $countones(valid_q) == $countones($past(valid_q)) + int'($past(in_fire)) - int'($past(out_fire)))

endmodule

// ===== verif/tb_disc_collision_response_unit.sv =====
// Self-checking testbench of disc_collision_response_unit: random and directed disc pairs.
// Depends on dcr_pkg and the unit RTL; a scoreboard class predicts every result.

class collision_scoreboard;
  dcr_pkg::out_t pending[$];
  logic [16:0]   restitution;
  int            errors;
  int            hits;
  int            checked;

  function new();
    restitution = dcr_pkg::EOne;
    errors = 0;
    hits = 0;
    checked = 0;
  endfunction

  static function longint shr_floor(longint x, int s);
    return x >>> s;
  endfunction

  static function logic signed [31:0] clamp32(longint v);
    longint r;
    r = v;
    if (v > 64'sd2147483647) r = 64'sd2147483647;
    if (v < -64'sd2147483648) r = -64'sd2147483648;
    return 32'(r);
  endfunction

  static function longint unsigned root_floor(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Predict the resolved pair and queue it.
  function void note_pair(dcr_pkg::in_t w);
    dcr_pkg::out_t o;
    longint p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y, dx, dy, nx, ny;
    longint vn1, vn2, vt1, vt2, g, sx, sy;
    longint unsigned r, r2, m1, m2, a, b, d2, dlen, e, q, w1, w2, half;
    bit hit;
    p1x = w.p1x; p1y = w.p1y; v1x = w.v1x; v1y = w.v1y;
    p2x = w.p2x; p2y = w.p2y; v2x = w.v2x; v2y = w.v2y;
    r = 64'(w.reach1) + 64'(w.reach2);
    m1 = 64'(w.mass1); m2 = 64'(w.mass2);
    r2 = r * r;
    dx = p2x - p1x; dy = p2y - p1y;
    a = (dx < 0 ? -dx : dx); a = a * a;
    b = (dy < 0 ? -dy : dy); b = b * b;
    hit = 0;
    d2 = 0;
    if (a < r2 && b < r2 && b <= ~64'd0 - a) begin
      d2 = a + b;
      hit = d2 > 0 && d2 < r2;
    end
    o = '0;
    if (!hit) begin
      o.p1x = w.p1x; o.p1y = w.p1y; o.v1x = w.v1x; o.v1y = w.v1y;
      o.p2x = w.p2x; o.p2y = w.p2y; o.v2x = w.v2x; o.v2y = w.v2y;
    end else begin
      dlen = root_floor(d2);
      nx = (dx * (64'sd1 <<< 28)) / longint'(dlen);
      ny = (dy * (64'sd1 <<< 28)) / longint'(dlen);
      vn1 = shr_floor(v1x * nx + v1y * ny, 28);
      vn2 = shr_floor(v2x * nx + v2y * ny, 28);
      vt1 = shr_floor(v1y * nx - v1x * ny, 28);
      vt2 = shr_floor(v2y * nx - v2x * ny, 28);
      if (m1 == 0) m1 = 1;
      if (m2 == 0) m2 = 1;
      e = restitution > dcr_pkg::EOne ? dcr_pkg::EOne : restitution;
      q = 65536 + e;
      w1 = ((m1 * q) << 8) / (m1 + m2);
      w2 = ((m2 * q) << 8) / (m1 + m2);
      g = vn1 - vn2;
      vn1 = vn1 - shr_floor(g * longint'(w2), 24);
      vn2 = vn2 + shr_floor(g * longint'(w1), 24);
      half = (r - dlen) / 2;
      sx = shr_floor(nx * longint'(half), 28);
      sy = shr_floor(ny * longint'(half), 28);
      o.hit = 1'b1;
      o.p1x = clamp32(p1x - sx);
      o.p1y = clamp32(p1y - sy);
      o.v1x = clamp32(shr_floor(nx * vn1 - ny * vt1, 28));
      o.v1y = clamp32(shr_floor(ny * vn1 + nx * vt1, 28));
      o.p2x = clamp32(p2x + sx);
      o.p2y = clamp32(p2y + sy);
      o.v2x = clamp32(shr_floor(nx * vn2 - ny * vt2, 28));
      o.v2y = clamp32(shr_floor(ny * vn2 + nx * vt2, 28));
    end
    pending.push_back(o);
  endfunction

  function void report_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Compare one accepted result with the oldest prediction.
  function void check_result(dcr_pkg::out_t act);
    dcr_pkg::out_t ex;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result word, expected none, actual hit=%0d", $time, act.hit);
      errors++;
      return;
    end
    ex = pending.pop_front();
    checked++;
    if (ex.hit) hits++;
    report_field("hit", ex.hit, act.hit);
    report_field("new_first_pos_x", ex.p1x, act.p1x);
    report_field("new_first_pos_y", ex.p1y, act.p1y);
    report_field("new_first_vel_x", ex.v1x, act.v1x);
    report_field("new_first_vel_y", ex.v1y, act.v1y);
    report_field("new_second_pos_x", ex.p2x, act.p2x);
    report_field("new_second_pos_y", ex.p2y, act.p2y);
    report_field("new_second_vel_x", ex.v2x, act.v2x);
    report_field("new_second_vel_y", ex.v2y, act.v2y);
  endfunction
endclass

module tb_disc_collision_response_unit;
  import dcr_pkg::*;

  localparam int Latency = 71;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i, hit_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [16:0] cfg_restitution_i;
  in_t pair_word;
  logic signed [31:0] np1x, np1y, nv1x, nv1y, np2x, np2y, nv2x, nv2y;

  collision_scoreboard board;
  bit calm;       // no idling in the last part of the run
  bit stim_done;

  disc_collision_response_unit uut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .first_pos_x_i(pair_word.p1x), .first_pos_y_i(pair_word.p1y),
    .first_vel_x_i(pair_word.v1x), .first_vel_y_i(pair_word.v1y),
    .second_pos_x_i(pair_word.p2x), .second_pos_y_i(pair_word.p2y),
    .second_vel_x_i(pair_word.v2x), .second_vel_y_i(pair_word.v2y),
    .first_reach_i(pair_word.reach1), .second_reach_i(pair_word.reach2),
    .first_mass_i(pair_word.mass1), .second_mass_i(pair_word.mass2),
    .out_valid_o, .out_ready_i, .hit_o,
    .new_first_pos_x_o(np1x), .new_first_pos_y_o(np1y),
    .new_first_vel_x_o(nv1x), .new_first_vel_y_o(nv1y),
    .new_second_pos_x_o(np2x), .new_second_pos_y_o(np2y),
    .new_second_vel_x_o(nv2x), .new_second_vel_y_o(nv2y),
    .cfg_valid_i, .cfg_ready_o, .cfg_restitution_i
  );

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  // Check every result word taken at a rising edge.
  always @(posedge clk_i) begin
    out_t act;
    if (rst_ni && out_valid_o && out_ready_i) begin
      act = {hit_o, np1x, np1y, nv1x, nv1y, np2x, np2y, nv2x, nv2y};
      board.check_result(act);
    end
  end

  // Stall the result side in random bursts; hold ready high when calm.
  initial begin
    int n;
    out_ready_i = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready_i = 0;
        n = $urandom_range(1, 6);
        repeat (n - 1) @(negedge clk_i);
      end else begin
        out_ready_i = 1;
      end
    end
  end

  // Offer one word; hold it until taken, then drop valid unless the next follows.
  task automatic send_pair(in_t w);
    int n;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid_i = 0;
      n = $urandom_range(1, 6);
      repeat (n) @(negedge clk_i);
    end
    pair_word = w;
    in_valid_i = 1;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_pair(w);
    @(negedge clk_i);
    in_valid_i = 0;
  endtask

  // Wait for all results, then let the pipe drain before touching the register.
  task automatic drain();
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (Latency + 5) @(negedge clk_i);
  endtask

  task automatic write_restitution(logic [16:0] value);
    cfg_restitution_i = value;
    cfg_valid_i = 1;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.restitution = value;
    @(negedge clk_i);
    cfg_valid_i = 0;
  endtask

  function automatic logic [31:0] rnd32();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 5))
      0: v = 32'h7FFFFFFF;
      1: v = 32'h80000000;
      2: v = 0;
      default: ;
    endcase
    return v;
  endfunction

  // Build a pair that mostly overlaps, at a random scale and offset.
  function automatic in_t overlap_pair();
    in_t w;
    int sh;
    logic signed [31:0] cx, cy;
    sh = $urandom_range(4, 26);
    cx = $urandom;
    cy = $urandom;
    if ($urandom_range(0, 3) != 0) begin
      cx = $signed(cx) >>> 4;
      cy = $signed(cy) >>> 4;
    end
    w.p1x = cx;
    w.p1y = cy;
    w.p2x = cx + ($signed($urandom) >>> (32 - sh));
    w.p2y = cy + ($signed($urandom) >>> (32 - sh));
    w.reach1 = 31'(($urandom >> (32 - sh)) + $urandom_range(0, 3));
    w.reach2 = 31'(($urandom >> (32 - sh)) + $urandom_range(0, 3));
    w.v1x = $signed($urandom) >>> $urandom_range(0, 12);
    w.v1y = $signed($urandom) >>> $urandom_range(0, 12);
    w.v2x = $signed($urandom) >>> $urandom_range(0, 12);
    w.v2y = $signed($urandom) >>> $urandom_range(0, 12);
    w.mass1 = 31'($urandom >> $urandom_range(1, 31));
    w.mass2 = 31'($urandom >> $urandom_range(1, 31));
    if ($urandom_range(0, 15) == 0) w.mass1 = 0;
    if ($urandom_range(0, 15) == 0) w.mass2 = 0;
    return w;
  endfunction

  function automatic in_t noise_pair();
    in_t w;
    w.p1x = rnd32(); w.p1y = rnd32(); w.v1x = rnd32(); w.v1y = rnd32();
    w.p2x = rnd32(); w.p2y = rnd32(); w.v2x = rnd32(); w.v2y = rnd32();
    w.reach1 = 31'(rnd32()); w.reach2 = 31'(rnd32());
    w.mass1 = 31'(rnd32()); w.mass2 = 31'(rnd32());
    return w;
  endfunction

  task automatic directed_pairs();
    in_t w;
    // Head-on overlap along x.
    w = '0;
    w.p2x = 32'sh0001_8000; w.reach1 = 31'h1_0000; w.reach2 = 31'h1_0000;
    w.v1x = 32'sh0002_0000; w.v2x = -32'sh0001_0000;
    w.mass1 = 31'h1_0000; w.mass2 = 31'h2_0000;
    send_pair(w);
    // Diagonal with tangential speed, zero masses.
    w.p2y = 32'sh0000_8000; w.v1y = 32'sh0003_0000; w.mass1 = 0; w.mass2 = 0;
    send_pair(w);
    // Coincident centres: no hit.
    w.p2x = 0; w.p2y = 0;
    send_pair(w);
    // Exactly touching: no hit.
    w.p2x = 32'sh0002_0000; w.p2y = 0;
    send_pair(w);
    // Far apart with huge coordinates.
    w.p1x = 32'sh8000_0000; w.p2x = 32'sh7FFF_FFFF;
    send_pair(w);
    // Huge reaches near the coordinate extremes: saturating corrections.
    w = '0;
    w.p1x = 32'sh7FFF_0000; w.p2x = 32'sh7FFF_FFFF; w.p1y = 32'sh8000_0000;
    w.p2y = 32'sh8000_0001; w.reach1 = 31'h7FFF_FFFF; w.reach2 = 31'h7FFF_FFFF;
    w.v1x = 32'sh7FFF_FFFF; w.v2x = 32'sh8000_0000; w.v1y = 32'sh8000_0000;
    w.v2y = 32'sh7FFF_FFFF; w.mass1 = 31'h7FFF_FFFF; w.mass2 = 1;
    send_pair(w);
    w.mass1 = 1; w.mass2 = 31'h7FFF_FFFF; w.p2x = 32'sh7FFF_0001;
    send_pair(w);
    // All-ones fields everywhere.
    w = '1;
    send_pair(w);
    w = '0;
    send_pair(w);
    repeat (12) send_pair(overlap_pair());
  endtask

  initial begin
    int total;
    board = new();
    calm = 0;
    stim_done = 0;
    rst_ni = 0;
    in_valid_i = 0;
    cfg_valid_i = 0;
    cfg_restitution_i = EOne;
    pair_word = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    directed_pairs();
    drain();
    total = 0;
    // Walk several restitution settings, the extremes and the clamp among them.
    for (int phase = 0; phase < 6; phase++) begin
      logic [16:0] e;
      case (phase)
        0: e = 17'd0;
        1: e = 17'h1FFFF;
        2: e = EOne;
        3: e = 17'd32768;
        4: e = EOne + 17'd1;
        default: e = 17'($urandom_range(0, 65536));
      endcase
      write_restitution(e);
      if (phase == 5) calm = 1;
      repeat (115) begin
        if ($urandom_range(0, 4) == 0) send_pair(noise_pair());
        else send_pair(overlap_pair());
        total++;
      end
      if (phase == 2) drain();  // an extra drain after this setting, before the next write
      drain();
    end
    stim_done = 1;
    drain();
    $display("Covered %0d random pairs and %0d results, %0d of them hits, over six settings.",
             total, board.checked, board.hits);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb_disc_collision_response_unit: done, clean");
    end else begin
      $display("tb_disc_collision_response_unit: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Run timed out.");
    $display("tb_disc_collision_response_unit: done, errors");
    $finish;
  end
endmodule
